/* rtl/core/jeu_pkg.sv */
// Shared types, constants and helper functions for the JSON escaper.
`timescale 1ns / 1ps
package jeu_pkg;

    localparam int QUEUE_DEPTH = 4;

    // UTF-8 boundaries
    localparam logic [7:0] B_ASCII_TOP = 8'h80;
    localparam logic [7:0] B_CTRL_TOP  = 8'h20;
    localparam logic [7:0] B_L2_LO     = 8'hC2;
    localparam logic [7:0] B_L2_HI     = 8'hDF;
    localparam logic [7:0] B_L3_LO     = 8'hE0;
    localparam logic [7:0] B_L3_HI     = 8'hEF;
    localparam logic [7:0] B_L4_LO     = 8'hF0;
    localparam logic [7:0] B_L4_HI     = 8'hF4;
    localparam logic [7:0] B_TOP2_MASK = 8'hC0;
    localparam logic [7:0] B_E0_MIN    = 8'hA0;
    localparam logic [7:0] B_ED_LEAD   = 8'hED;
    localparam logic [7:0] B_F0_MIN    = 8'h90;
    localparam logic [7:0] B_F4_MAX    = 8'h8F;

    // ASCII characters with short escapes
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A_M10 = 8'h57;  // 'a' - 10

    localparam logic [2:0] REPL_LEN  = 3'd6;
    localparam logic [2:0] REPL_LAST = 3'd5;
    // "\ufffd", element 0 goes out first
    localparam logic [5:0][7:0] REPL_STR = {8'h64, 8'h66, 8'h66, 8'h66, 8'h75, 8'h5C};

    typedef struct packed {
        logic [2:0]      len;
        logic [5:0][7:0] bytes;
    } t_esc;

    // One queued work item: replacement run, literal bytes, replacement run
    typedef struct packed {
        logic [1:0]      pre_n;
        logic [2:0]      mid_len;
        logic [5:0][7:0] mid;
        logic [1:0]      post_n;
        logic            last;
    } t_job;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_MID,
        PH_POST
    } t_phase;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        begin
            w = {4'h0, v};
            return (v < 4'd10) ? (w + CH_ZERO) : (w + CH_A_M10);
        end
    endfunction

    function automatic t_esc esc_ascii(input logic [7:0] c);
        t_esc e;
        begin
            e.len      = 3'd1;
            e.bytes    = '0;
            e.bytes[0] = c;
            case (c)
                CH_QUOTE, CH_BSL: begin
                    e.len = 3'd2; e.bytes[0] = CH_BSL; e.bytes[1] = c;
                end
                CH_BS: begin
                    e.len = 3'd2; e.bytes[0] = CH_BSL; e.bytes[1] = CH_B;
                end
                CH_FF: begin
                    e.len = 3'd2; e.bytes[0] = CH_BSL; e.bytes[1] = CH_F;
                end
                CH_LF: begin
                    e.len = 3'd2; e.bytes[0] = CH_BSL; e.bytes[1] = CH_N;
                end
                CH_CR: begin
                    e.len = 3'd2; e.bytes[0] = CH_BSL; e.bytes[1] = CH_R;
                end
                CH_TAB: begin
                    e.len = 3'd2; e.bytes[0] = CH_BSL; e.bytes[1] = CH_T;
                end
                default: begin
                    if (c < B_CTRL_TOP) begin
                        e.len      = 3'd6;
                        e.bytes[0] = CH_BSL;
                        e.bytes[1] = CH_U;
                        e.bytes[2] = CH_ZERO;
                        e.bytes[3] = CH_ZERO;
                        e.bytes[4] = hex_digit(c[7:4]);
                        e.bytes[5] = hex_digit(c[3:0]);
                    end
                end
            endcase
            return e;
        end
    endfunction

endpackage

/* rtl/core/jeu_front.sv */
// Front end: UTF-8 sequence tracking and per-word job classification.
`timescale 1ns / 1ps
module jeu_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_in_byte,
    input  logic           i_text_last,
    input  logic           i_full,
    output logic           o_push,
    output jeu_pkg::t_job  o_job
);
    import jeu_pkg::*;

    logic [7:0] r_lead, n_lead;
    logic [1:0] r_cnt, n_cnt;
    logic [2:0] r_exp, n_exp;
    logic [7:0] r_cont [2];
    logic [7:0] n_cont [2];
    logic       cont_ok;
    logic       fresh;
    logic       accept;
    t_esc       esc;
    t_job       job;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        cont_ok = (i_in_byte & B_TOP2_MASK) == B_ASCII_TOP;
        if (r_cnt == 2'd0) begin
            if ((r_lead == B_L3_LO && i_in_byte < B_E0_MIN) ||
                (r_lead == B_ED_LEAD && i_in_byte >= B_E0_MIN) ||
                (r_lead == B_L4_LO && i_in_byte < B_F0_MIN) ||
                (r_lead == B_L4_HI && i_in_byte > B_F4_MAX))
                cont_ok = 1'b0;
        end
    end

    always_comb begin
        job       = '0;
        job.last  = i_text_last;
        n_lead    = r_lead;
        n_cnt     = r_cnt;
        n_exp     = r_exp;
        n_cont[0] = r_cont[0];
        n_cont[1] = r_cont[1];
        fresh     = 1'b1;
        esc       = esc_ascii(i_in_byte);
        if (r_exp != 3'd0) begin
            if (cont_ok) begin
                fresh = 1'b0;
                if (({1'b0, r_cnt} + 3'd2) >= r_exp) begin
                    // sequence complete, pass it through
                    job.mid_len = {1'b0, r_cnt} + 3'd2;
                    job.mid[0]  = r_lead;
                    job.mid[1]  = (r_cnt != 2'd0) ? r_cont[0] : i_in_byte;
                    job.mid[2]  = (r_cnt == 2'd2) ? r_cont[1] : i_in_byte;
                    job.mid[3]  = i_in_byte;
                    n_lead = '0;
                    n_cnt  = '0;
                    n_exp  = '0;
                end else begin
                    n_cont[r_cnt[0]] = i_in_byte;
                    n_cnt = r_cnt + 2'd1;
                end
            end else begin
                // broken sequence: one replacement per held byte
                job.pre_n = r_cnt + 2'd1;
                n_lead = '0;
                n_cnt  = '0;
                n_exp  = '0;
            end
        end
        if (fresh) begin
            if (i_in_byte < B_ASCII_TOP) begin
                job.mid_len = esc.len;
                job.mid     = esc.bytes;
            end else if (i_in_byte >= B_L2_LO && i_in_byte <= B_L2_HI) begin
                n_lead = i_in_byte; n_cnt = '0; n_exp = 3'd2;
            end else if (i_in_byte >= B_L3_LO && i_in_byte <= B_L3_HI) begin
                n_lead = i_in_byte; n_cnt = '0; n_exp = 3'd3;
            end else if (i_in_byte >= B_L4_LO && i_in_byte <= B_L4_HI) begin
                n_lead = i_in_byte; n_cnt = '0; n_exp = 3'd4;
            end else begin
                job.mid_len = REPL_LEN;
                job.mid     = REPL_STR;
            end
        end
        if (i_text_last && n_exp != 3'd0) begin
            // string ends inside a sequence
            job.post_n = n_cnt + 2'd1;
            n_lead = '0;
            n_cnt  = '0;
            n_exp  = '0;
        end
    end

    assign o_job  = job;
    assign o_push = accept &&
                    (job.pre_n != 2'd0 || job.mid_len != 3'd0 || job.post_n != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= '0;
            r_cnt  <= '0;
            r_exp  <= '0;
        end else if (accept) begin
            r_lead <= n_lead;
            r_cnt  <= n_cnt;
            r_exp  <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cont[0] <= n_cont[0];
            r_cont[1] <= n_cont[1];
        end
    end

endmodule

/* rtl/core/jeu_queue.sv */
// Small job queue between front end and output sequencer.
`timescale 1ns / 1ps
module jeu_queue #(
    parameter int DEPTH = jeu_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jeu_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output jeu_pkg::t_job  o_job
);
    import jeu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push)
            r_mem[r_wr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push)
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + AW'(1);
            if (do_pop)
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + AW'(1);
            if (do_push && !do_pop)
                r_cnt <= r_cnt + CW'(1);
            else if (do_pop && !do_push)
                r_cnt <= r_cnt - CW'(1);
        end
    end

endmodule

/* rtl/core/jeu_back.sv */
// Back end: expands queued jobs into output words, one per cycle unless the output is stalled.
`timescale 1ns / 1ps
module jeu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  jeu_pkg::t_job  i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_run_end,
    output logic           o_text_end
);
    import jeu_pkg::*;

    t_phase     r_phase, n_phase;
    t_phase     eff;
    logic [2:0] r_idx, n_idx;
    logic [1:0] r_rep, n_rep;
    logic       adv;
    logic       seg_end;
    logic       done;
    logic [7:0] cur_byte;

    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_run_end;
    logic       r_text_end;

    assign adv = i_q_valid && (!r_ov || i_ready);

    // output block: current word and segment boundaries
    always_comb begin
        eff = r_phase;
        if (eff == PH_PRE && i_job.pre_n == 2'd0)
            eff = PH_MID;
        if (eff == PH_MID && i_job.mid_len == 3'd0)
            eff = PH_POST;
        cur_byte = REPL_STR[r_idx];
        seg_end  = 1'b0;
        done     = 1'b0;
        case (eff)
            PH_PRE: begin
                seg_end = (r_idx == REPL_LAST) && (r_rep == i_job.pre_n - 2'd1);
                done    = seg_end && i_job.mid_len == 3'd0 && i_job.post_n == 2'd0;
            end
            PH_MID: begin
                cur_byte = i_job.mid[r_idx];
                seg_end  = (r_idx == i_job.mid_len - 3'd1);
                done     = seg_end && i_job.post_n == 2'd0;
            end
            PH_POST: begin
                seg_end = (r_idx == REPL_LAST) && (r_rep == i_job.post_n - 2'd1);
                done    = seg_end;
            end
            default: begin
                seg_end = 1'b1;
                done    = 1'b1;
            end
        endcase
    end

    // next-state block
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_rep   = r_rep;
        if (adv) begin
            if (done) begin
                n_phase = PH_PRE;
                n_idx   = '0;
                n_rep   = '0;
            end else if (seg_end) begin
                n_phase = (eff == PH_PRE) ? PH_MID : PH_POST;
                n_idx   = '0;
                n_rep   = '0;
            end else if (eff != PH_MID && r_idx == REPL_LAST) begin
                n_idx = '0;
                n_rep = r_rep + 2'd1;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
    end

    assign o_pop = adv && done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PRE;
            r_idx   <= '0;
            r_rep   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_rep   <= n_rep;
            if (!r_ov || i_ready)
                r_ov <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_byte     <= cur_byte;
            r_run_end  <= done;
            r_text_end <= done && i_job.last;
        end
    end

    assign o_valid    = r_ov;
    assign o_out_byte = r_byte;
    assign o_run_end  = r_run_end;
    assign o_text_end = r_text_end;

endmodule

/* rtl/core/json_escape_utf8_validate.sv */
// JSON string escaper with UTF-8 validation: top level.
//
// Takes one text byte per word and emits the JSON-escaped form, one output
// byte per word. Quote and backslash are escaped, BS FF LF CR TAB get short
// escapes, other controls become \u00xx (lowercase hex), other ASCII passes.
// Well-formed 2..4 byte UTF-8 sequences are held until complete and then
// passed through; any malformed byte, and each byte of a broken or truncated
// sequence, becomes \ufffd. run_end marks the last output word caused by an
// input word, text_end the last one of the whole string. A lead or a middle
// continuation byte produces no output of its own.
// Rate: the input side takes one word per cycle as long as the job queue
// (QDEPTH entries) has room; the output sequencer drives one word per cycle
// unless the output is stalled; an input word costs k output words (1 for
// plain text, up to 24 for a broken 4-byte sequence). Each job is written
// into the job queue, and the back end registers its output words from there.
`timescale 1ns / 1ps
module json_escape_utf8_validate #(
    parameter int QDEPTH = jeu_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_text_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_run_end,
    output logic       o_text_end
);
    import jeu_pkg::*;

    t_job push_job, head_job;
    logic push, full, q_valid, pop;

    // classify input words into jobs
    jeu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_text_last (i_text_last),
        .i_full      (full),
        .o_push      (push),
        .o_job       (push_job)
    );

    // decouples input stalls from output backpressure
    jeu_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    // expand jobs into output words
    jeu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_job      (head_job),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_run_end  (o_run_end),
        .o_text_end (o_text_end)
    );

endmodule

/* rtl/core/jeu_checker.sv */
// Port-level checker for the JSON escaper, bound to the top level.
`timescale 1ns / 1ps
module jeu_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic [7:0] i_in_byte,
    input logic       i_text_last,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_run_end,
    input logic       o_text_end
);

    // end of string is always the end of a run
    a_text_end_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_text_end |-> o_run_end)
        else $error("text_end without run_end");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) &&
                                $stable(o_run_end) && $stable(o_text_end))
        else $error("output word changed while stalled");

    // out of reset: nothing pending, input side open
    a_reset_state: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_valid && o_ready)
        else $error("bad state after reset");

endmodule

bind json_escape_utf8_validate jeu_checker u_jeu_checker (.*);
